@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wmp_pkg.sv @@
package wmp_pkg;

    localparam int PIX_W    = 8;
    localparam int DIM_W    = 9;
    localparam int WIN_W    = 4;
    localparam int PC_W     = 11;
    localparam int PI_W     = 10;
    localparam int PC_MAX   = 1024;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic signed [PIX_W-1:0] PIX_MIN = 8'sh80;

    typedef enum logic [2:0] {
        REG_PLANE_HEIGHT  = 3'd0,
        REG_PLANE_WIDTH   = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WINDOW_WIDTH  = 3'd3,
        REG_STEP_SIZE     = 3'd4,
        REG_PLANE_COUNT   = 3'd5
    } wmp_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0] plane_height;
        logic [DIM_W-1:0] plane_width;
        logic [WIN_W-1:0] window_height;
        logic [WIN_W-1:0] window_width;
        logic [WIN_W-1:0] step_size;
        logic [PC_W-1:0]  plane_count;
    } wmp_cfg_t;

    localparam wmp_cfg_t CFG_RESET = '{
        plane_height:  9'd32,
        plane_width:   9'd32,
        window_height: 4'd2,
        window_width:  4'd2,
        step_size:     4'd2,
        plane_count:   11'd1
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FOLD,
        ST_DONE
    } wmp_state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
    } wmp_cmd_t;

    typedef struct packed {
        logic closes;
        logic rd_last;
        logic out_free;
    } wmp_status_t;

endpackage

@@ sv/wmp_ram.sv @@
module wmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/wmp_ctrl.sv @@
`include "assert_macros.svh"

module wmp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output wmp_pkg::wmp_cmd_t    cmd,
    input  wmp_pkg::wmp_status_t status
);

    import wmp_pkg::*;

    wmp_state_t state_reg;
    wmp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && status.closes)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
                if (status.rd_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_close_starts_read, cmd.accept && status.closes, state_reg == ST_READ, "closing beat did not start window read")
    `ASSERT_NEXT(a_last_read_folds, state_reg == ST_READ && status.rd_last, state_reg == ST_FOLD, "read sweep did not end in fold")
    `ASSERT_NEXT(a_done_waits, state_reg == ST_DONE && !status.out_free, state_reg == ST_DONE, "result dropped while output busy")

endmodule

@@ sv/wmp_datapath.sv @@
`include "assert_macros.svh"

module wmp_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WINDOW = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  wmp_pkg::wmp_cfg_t                      cfg,
    input  logic                                   restart,
    input  wmp_pkg::wmp_cmd_t                      cmd,
    output wmp_pkg::wmp_status_t                   status,
    input  logic signed [wmp_pkg::PIX_W-1:0]       pixel,
    input  logic                                   out_stall,
    output logic                                   out_valid,
    output logic signed [wmp_pkg::PIX_W-1:0]       pooled,
    output logic                                   plane_done,
    output logic                                   frame_done
);

    import wmp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = $clog2(MAX_WINDOW);
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int PW = (CW > RW) ? CW : RW;
    localparam int EW = PW + 5;
    localparam int XW = (EW > PC_W) ? EW : PC_W;
    localparam int NL = 2 ** SW;

    // effective (saturated) settings
    logic [EW-1:0]   h_eff;
    logic [EW-1:0]   w_eff;
    logic [EW-1:0]   kh_e;
    logic [EW-1:0]   kw_e;
    logic [EW-1:0]   st_e;
    logic [KW-1:0]   kh_k;
    logic [KW-1:0]   kw_k;
    logic [PC_W-1:0] pc_e;

    always_comb
    begin
        if (cfg.plane_height == '0)
            h_eff = EW'(1);
        else if (XW'(cfg.plane_height) > XW'(MAX_HEIGHT))
            h_eff = EW'(MAX_HEIGHT);
        else
            h_eff = EW'(cfg.plane_height);

        if (cfg.plane_width == '0)
            w_eff = EW'(1);
        else if (XW'(cfg.plane_width) > XW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = EW'(cfg.plane_width);

        if (cfg.window_height == '0)
            kh_e = EW'(1);
        else if ({1'b0, cfg.window_height} > 5'(MAX_WINDOW))
            kh_e = EW'(MAX_WINDOW);
        else
            kh_e = EW'(cfg.window_height);

        if (cfg.window_width == '0)
            kw_e = EW'(1);
        else if ({1'b0, cfg.window_width} > 5'(MAX_WINDOW))
            kw_e = EW'(MAX_WINDOW);
        else
            kw_e = EW'(cfg.window_width);

        st_e = (cfg.step_size == '0) ? EW'(1) : EW'(cfg.step_size);

        if (cfg.plane_count == '0)
            pc_e = PC_W'(1);
        else if (cfg.plane_count > PC_W'(PC_MAX))
            pc_e = PC_W'(PC_MAX);
        else
            pc_e = cfg.plane_count;

        kh_k = KW'(kh_e);
        kw_k = KW'(kw_e);
    end

    // scan position state
    logic [RW-1:0]   row_reg,   row_next;
    logic [CW-1:0]   col_reg,   col_next;
    logic [EW-1:0]   wro_reg,   wro_next;
    logic [EW-1:0]   wco_reg,   wco_next;
    logic [SW-1:0]   slot_reg,  slot_next;
    logic [PI_W-1:0] plane_reg, plane_next;

    logic [EW-1:0] row_e;
    logic [EW-1:0] col_e;
    logic [KW-1:0] slot_inc;
    logic          row_closes;
    logic          win_closes;
    logic          last_col;
    logic          last_row;
    logic          last_plane;
    logic          col_end;
    logic          row_end;

    always_comb
    begin
        row_e      = EW'(row_reg);
        col_e      = EW'(col_reg);
        row_closes = (row_e == wro_reg + kh_e - EW'(1));
        win_closes = row_closes && (col_e == wco_reg + kw_e - EW'(1));
        last_col   = (wco_reg + st_e + kw_e - EW'(1)) >= w_eff;
        last_row   = (wro_reg + st_e + kh_e - EW'(1)) >= h_eff;
        last_plane = (PC_W'(plane_reg) + PC_W'(1)) >= pc_e;
        col_end    = (col_e + EW'(1)) >= w_eff;
        row_end    = (row_e + EW'(1)) >= h_eff;
        slot_inc   = KW'(slot_reg) + KW'(1);

        row_next   = row_reg;
        col_next   = col_reg;
        wro_next   = wro_reg;
        wco_next   = wco_reg;
        slot_next  = slot_reg;
        plane_next = plane_reg;

        if (restart)
        begin
            row_next   = '0;
            col_next   = '0;
            wro_next   = '0;
            wco_next   = '0;
            slot_next  = '0;
            plane_next = '0;
        end
        else if (cmd.accept)
        begin
            if (col_end)
            begin
                col_next  = '0;
                wco_next  = '0;
                slot_next = (slot_inc >= kh_k) ? '0 : SW'(slot_inc);
                if (row_closes)
                begin
                    wro_next = wro_reg + st_e;
                end
                if (row_end)
                begin
                    row_next   = '0;
                    wro_next   = '0;
                    slot_next  = '0;
                    plane_next = last_plane ? '0 : plane_reg + PI_W'(1);
                end
                else
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
                if (win_closes)
                begin
                    wco_next = wco_reg + st_e;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            wro_reg   <= '0;
            wco_reg   <= '0;
            slot_reg  <= '0;
            plane_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            wro_reg   <= wro_next;
            wco_reg   <= wco_next;
            slot_reg  <= slot_next;
            plane_reg <= plane_next;
        end
    end

    // window read sweep: one column per cycle across all row banks
    logic [CW-1:0] rd_col_reg;
    logic [SW-1:0] kx_reg, kx_next;
    logic [CW-1:0] rd_addr;
    logic          fold_reg;
    logic          pd_reg;
    logic          fd_reg;
    logic signed [PIX_W-1:0] max_reg, max_next;

    logic [PIX_W-1:0]        bank_q [NL];
    logic signed [PIX_W-1:0] node   [1:2*NL-1];

    assign rd_addr = rd_col_reg - CW'(kx_reg);

    for (genvar b = 0; b < NL; b++)
    begin : g_bank
        if (b < MAX_WINDOW)
        begin : g_ram
            wmp_ram #(
                .WIDTH(PIX_W),
                .DEPTH(MAX_WIDTH)
            ) u_bank (
                .clk  (clk),
                .we   (cmd.accept && (slot_reg == SW'(b))),
                .waddr(col_reg),
                .wdata(pixel),
                .re   (cmd.rd),
                .raddr(rd_addr),
                .rdata(bank_q[b])
            );
        end
        else
        begin : g_pad
            assign bank_q[b] = PIX_MIN;
        end
    end

    // column maximum, balanced tree over the row banks
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            node[NL + i] = (KW'(i) < kh_k) ? $signed(bank_q[i]) : PIX_MIN;
        end
        for (int i = NL - 1; i >= 1; i--)
        begin
            node[i] = (node[2*i] > node[2*i + 1]) ? node[2*i] : node[2*i + 1];
        end
    end

    always_comb
    begin
        kx_next  = kx_reg;
        max_next = max_reg;
        if (cmd.accept && win_closes)
        begin
            kx_next  = '0;
            max_next = PIX_MIN;
        end
        else
        begin
            if (cmd.rd)
            begin
                kx_next = kx_reg + SW'(1);
            end
            if (fold_reg && (node[1] > max_reg))
            begin
                max_next = node[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_reg <= 1'b0;
        end
        else
        begin
            fold_reg <= cmd.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg  <= kx_next;
        max_reg <= max_next;
        if (cmd.accept && win_closes)
        begin
            rd_col_reg <= col_reg;
            pd_reg     <= last_col && last_row;
            fd_reg     <= last_col && last_row && last_plane;
        end
    end

    // output register
    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] pooled_reg;
    logic                    pd_out_reg;
    logic                    fd_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pooled_reg <= max_reg;
            pd_out_reg <= pd_reg;
            fd_out_reg <= fd_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pooled     = pooled_reg;
    assign plane_done = pd_out_reg;
    assign frame_done = fd_out_reg;

    assign status.closes   = win_closes;
    assign status.rd_last  = (KW'(kx_reg) + KW'(1)) == kw_k;
    assign status.out_free = !out_valid_reg || !out_stall;

    `ASSERT_IMPLY(a_frame_implies_plane, out_valid_reg, !fd_out_reg || pd_out_reg, "frame_done without plane_done")
    `ASSERT_IMPLY(a_read_in_window, cmd.rd, KW'(kx_reg) < kw_k, "read column outside window")
    `ASSERT_IMPLY(a_no_accept_in_fold, fold_reg, !cmd.accept, "pixel accepted during window fold")

endmodule

@@ sv/int8_window_max_pool_core.sv @@
// Streaming 2-D max pooling of signed 8-bit pixels, taken one per beat in raster
// order, plane after plane. Windows start on multiples of step_size with no padding;
// each window's maximum is returned once its bottom-right pixel arrives, with
// plane_done/frame_done on the last result of a plane/frame. A pixel that closes
// no window leaves the block ready for the next pixel. After a pixel that closes
// a window, the input stalls while the window is read one column per cycle,
// where MAX_WINDOW row banks of MAX_WIDTH entries are read in parallel and
// reduced, then folded and handed off into the output register, plus any
// wait while that register still holds an untaken result. New pixels are
// accepted while a result waits there. Any write to a configuration register
// restarts the frame at row 0, column 0, plane 0.
module int8_window_max_pool_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_WINDOW = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [wmp_pkg::PIX_W-1:0]     pixel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [wmp_pkg::PIX_W-1:0]     pooled,
    output logic                                 plane_done,
    output logic                                 frame_done,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wmp_pkg::ADDR_W-1:0]           paddr,
    input  logic [wmp_pkg::DATA_W-1:0]           pwdata,
    output logic [wmp_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);

    import wmp_pkg::*;

    wmp_cfg_t    cfg_reg, cfg_next;
    logic        cfg_wr;
    logic        restart;
    logic [2:0]  reg_idx;
    wmp_cmd_t    cmd;
    wmp_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        prdata   = '0;
        unique case (reg_idx)
            REG_PLANE_HEIGHT:
            begin
                prdata = DATA_W'(cfg_reg.plane_height);
                restart = cfg_wr;
                cfg_next.plane_height = pwdata[DIM_W-1:0];
            end
            REG_PLANE_WIDTH:
            begin
                prdata = DATA_W'(cfg_reg.plane_width);
                restart = cfg_wr;
                cfg_next.plane_width = pwdata[DIM_W-1:0];
            end
            REG_WINDOW_HEIGHT:
            begin
                prdata = DATA_W'(cfg_reg.window_height);
                restart = cfg_wr;
                cfg_next.window_height = pwdata[WIN_W-1:0];
            end
            REG_WINDOW_WIDTH:
            begin
                prdata = DATA_W'(cfg_reg.window_width);
                restart = cfg_wr;
                cfg_next.window_width = pwdata[WIN_W-1:0];
            end
            REG_STEP_SIZE:
            begin
                prdata = DATA_W'(cfg_reg.step_size);
                restart = cfg_wr;
                cfg_next.step_size = pwdata[WIN_W-1:0];
            end
            REG_PLANE_COUNT:
            begin
                prdata = DATA_W'(cfg_reg.plane_count);
                restart = cfg_wr;
                cfg_next.plane_count = pwdata[PC_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            cfg_reg <= cfg_next;
        end
    end

    wmp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd     (cmd),
        .status  (status)
    );

    wmp_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_WINDOW(MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .restart   (restart),
        .cmd       (cmd),
        .status    (status),
        .pixel     (pixel),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pooled    (pooled),
        .plane_done(plane_done),
        .frame_done(frame_done)
    );

endmodule

@@ bench/int8_window_max_pool_core_test.sv @@
module int8_window_max_pool_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wmp_pkg::*;

    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int MAX_WIN     = 8;
    localparam int IDLE_TAIL   = 24;
    localparam int HOLD_CYCLES = 500;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [PIX_W-1:0] pooled;
        logic                    plane_done;
        logic                    frame_done;
    } pool_result_t;

    // Tracks the pooling state and holds the window maxima still owed by the block.
    class pool_scoreboard;
        logic [DIM_W-1:0]        rows_cfg;
        logic [DIM_W-1:0]        cols_cfg;
        logic [WIN_W-1:0]        win_rows_cfg;
        logic [WIN_W-1:0]        win_cols_cfg;
        logic [WIN_W-1:0]        step_cfg;
        logic [PC_W-1:0]         planes_cfg;
        logic signed [PIX_W-1:0] ring [MAX_WIN][MAX_W];
        int unsigned             row_at;
        int unsigned             col_at;
        int unsigned             win_row_at;
        int unsigned             win_col_at;
        int unsigned             ring_at;
        int unsigned             plane_at;
        pool_result_t            awaited[$];
        int                      errors;

        function new();
            rows_cfg     = CFG_RESET.plane_height;
            cols_cfg     = CFG_RESET.plane_width;
            win_rows_cfg = CFG_RESET.window_height;
            win_cols_cfg = CFG_RESET.window_width;
            step_cfg     = CFG_RESET.step_size;
            planes_cfg   = CFG_RESET.plane_count;
            errors       = 0;
            restart();
        endfunction

        function void restart();
            row_at     = 0;
            col_at     = 0;
            win_row_at = 0;
            win_col_at = 0;
            ring_at    = 0;
            plane_at   = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void write_reg(wmp_reg_t r, logic [DATA_W-1:0] v);
            case (r)
                REG_PLANE_HEIGHT:  rows_cfg     = v[DIM_W-1:0];
                REG_PLANE_WIDTH:   cols_cfg     = v[DIM_W-1:0];
                REG_WINDOW_HEIGHT: win_rows_cfg = v[WIN_W-1:0];
                REG_WINDOW_WIDTH:  win_cols_cfg = v[WIN_W-1:0];
                REG_STEP_SIZE:     step_cfg     = v[WIN_W-1:0];
                REG_PLANE_COUNT:   planes_cfg   = v[PC_W-1:0];
                default: ;
            endcase
            restart();
        endfunction

        function void take_pixel(logic signed [PIX_W-1:0] px);
            int unsigned             h, w, kh, kw, st, pc;
            int unsigned             col, slot, src, ky, kx;
            logic signed [PIX_W-1:0] peak;
            bit                      row_closes, last_col, last_row;
            pool_result_t            res;
            h  = clamp(rows_cfg, 1, MAX_H);
            w  = clamp(cols_cfg, 1, MAX_W);
            kh = clamp(win_rows_cfg, 1, MAX_WIN);
            kw = clamp(win_cols_cfg, 1, MAX_WIN);
            st = clamp(step_cfg, 1, 15);
            pc = clamp(planes_cfg, 1, PC_MAX);
            col  = (col_at >= w) ? w - 1 : col_at;
            slot = ring_at % kh;
            ring[slot][col] = px;
            row_closes = (row_at == win_row_at + kh - 1);
            if (row_closes && col == win_col_at + kw - 1)
            begin
                peak = PIX_MIN;
                for (ky = 0; ky < kh; ky++)
                begin
                    src = (slot + kh - ky) % kh;
                    for (kx = 0; kx < kw; kx++)
                    begin
                        if (ring[src][col - kx] > peak)
                            peak = ring[src][col - kx];
                    end
                end
                last_col = (win_col_at + st + kw - 1 >= w);
                last_row = (win_row_at + st + kh - 1 >= h);
                res.pooled     = peak;
                res.plane_done = last_col && last_row;
                res.frame_done = last_col && last_row && (plane_at + 1 >= pc);
                awaited.push_back(res);
                win_col_at += st;
            end
            if (col + 1 >= w)
            begin
                col_at     = 0;
                win_col_at = 0;
                if (row_closes)
                    win_row_at += st;
                ring_at = (slot + 1) % kh;
                if (row_at + 1 >= h)
                begin
                    row_at     = 0;
                    win_row_at = 0;
                    ring_at    = 0;
                    plane_at   = (plane_at + 1 >= pc) ? 0 : plane_at + 1;
                end
                else
                begin
                    row_at++;
                end
            end
            else
            begin
                col_at = col + 1;
            end
        endfunction

        function void check_result(logic signed [PIX_W-1:0] p, logic pd, logic fd);
            pool_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got pooled %0d", $time, p);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (p !== want.pooled)
            begin
                $display("%0t: pooled expected %0d got %0d", $time, want.pooled, p);
                errors++;
            end
            if (pd !== want.plane_done)
            begin
                $display("%0t: plane_done expected %b got %b", $time, want.plane_done, pd);
                errors++;
            end
            if (fd !== want.frame_done)
            begin
                $display("%0t: frame_done expected %b got %b", $time, want.frame_done, fd);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [PIX_W-1:0] pixel;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [PIX_W-1:0] pooled;
    logic                    plane_done;
    logic                    frame_done;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    pool_scoreboard board = new();
    bit             no_idle = 1'b0;
    bit             hold_off_req = 1'b0;

    int8_window_max_pool_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pooled     (pooled),
        .plane_done (plane_done),
        .frame_done (frame_done),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] noisy(int v);
        return DATA_W'(v) | ({$urandom} << PC_W);
    endfunction

    task automatic send_pixel(input logic signed [PIX_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= v;
        do
            @(posedge clk);
        while (in_stall);
        board.take_pixel(v);
    endtask

    task automatic send_run(input int n);
        repeat (n) send_pixel(PIX_W'($urandom));
    endtask

    // wait out every owed beat, then let a trailing non-closing pixel finish
    task automatic settle();
        in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic set_reg(input wmp_reg_t r, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(r, v);
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [DATA_W-1:0] h, input logic [DATA_W-1:0] w,
                                 input logic [DATA_W-1:0] kh, input logic [DATA_W-1:0] kw,
                                 input logic [DATA_W-1:0] st, input logic [DATA_W-1:0] pc);
        settle();
        set_reg(REG_PLANE_HEIGHT, h);
        set_reg(REG_PLANE_WIDTH, w);
        set_reg(REG_WINDOW_HEIGHT, kh);
        set_reg(REG_WINDOW_WIDTH, kw);
        set_reg(REG_STEP_SIZE, st);
        set_reg(REG_PLANE_COUNT, pc);
    endtask

    initial
    begin : result_sink
        int stall_left;
        int burst;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(pooled, plane_done, frame_done);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                burst = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                out_stall <= (burst > 0);
                stall_left = (burst > 0) ? burst - 1 : 0;
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        int h, w, kh, kw, st, pc, n;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        pixel    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two 2x2 planes: all-minimum window, then mixed extremes
        apply_setting(2, 2, 2, 2, 2, 2);
        send_pixel(-128);
        send_pixel(-128);
        send_pixel(-128);
        send_pixel(-128);
        send_pixel(127);
        send_pixel(-128);
        send_pixel(0);
        send_pixel(-1);

        // window taller than plane: no beats, planes still counted
        apply_setting(1, 2, 2, 2, 2, 3);
        send_pixel(1);
        send_pixel(2);
        send_pixel(3);
        send_pixel(4);
        send_pixel(5);
        send_pixel(6);

        // zero registers saturate to 1, every pixel closes a window
        apply_setting(0, 3, 0, 0, 0, 0);
        send_pixel(5);
        send_pixel(-5);
        send_pixel(100);

        // register write mid-plane restarts the frame
        apply_setting(2, 2, 2, 2, 2, 1);
        send_pixel(60);
        send_pixel(61);
        settle();
        set_reg(REG_PLANE_COUNT, 1);
        send_pixel(-3);
        send_pixel(-7);
        send_pixel(-9);
        send_pixel(-2);

        // width above range, full-width row of 8-wide windows
        apply_setting(2, 511, 1, 8, 8, 1);
        send_run(264);

        // height above range, single column
        apply_setting(511, 1, 1, 1, 8, 1);
        send_run(256);

        // plane count above range, one pixel per plane; sink holds off meanwhile
        apply_setting(1, 1, 1, 1, 1, 2047);
        hold_off_req = 1'b1;
        send_run(1030);

        // largest windows, window height above range
        apply_setting(9, 10, 15, 8, 1, 1);
        send_run(100);

        repeat (8)
        begin
            h  = $urandom_range(0, 8);
            w  = $urandom_range(0, 8);
            kh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            kw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
            st = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
            pc = $urandom_range(0, 3);
            apply_setting(noisy(h), noisy(w), noisy(kh), noisy(kw), noisy(st), noisy(pc));
            no_idle = ($urandom_range(0, 3) == 0);
            n = (h == 0 ? 1 : h) * (w == 0 ? 1 : w) * (pc == 0 ? 1 : pc)
                + $urandom_range(0, 8);
            send_run(n > 120 ? 120 : n);
            no_idle = 1'b0;
        end

        settle();
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
